// ===== rtl/lkv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lkv_pkg;

   // Defaults handed to the top level parameters
   localparam int DEF_ENTRIES  = 16;
   localparam int DEF_KEY_BITS = 32;

   // Fixed field widths
   localparam int DATA_W    = 32;
   localparam int CAP_W     = 5;
   localparam int CAP_RESET = 16;

   // Value returned on a get miss and for every put
   localparam logic [DATA_W-1:0] MISS_VALUE = '1;

   // Request kinds
   typedef enum logic {
      KIND_GET = 1'b0,
      KIND_PUT = 1'b1
   } kind_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_DONE
   } state_type;

   // Scan unit status towards the sequencer
   typedef struct packed {
      logic hit_now;   // match seen at the compare stage this cycle
      logic hit;       // a matching entry has been recorded
      logic old_ok;    // an oldest valid entry has been recorded
      logic free_ok;   // a free entry has been recorded
   } scan_flags_type;

   // Store update command from the sequencer
   typedef struct packed {
      logic apply;        // promote slot and mark it valid
      logic all_age;      // age every other valid entry (insert)
      logic write_key;
      logic write_value;
   } upd_cmd_type;

endpackage

// ===== rtl/lkv_store.sv =====
// Entry storage: key and value memories, valid marks and recency ages.
// Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_store
   import lkv_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES,
   parameter int KW      = DEF_KEY_BITS,
   parameter int IW      = 4
) (
   input  logic              clock,
   input  logic              reset,
   // scan read port
   input  logic              rd_en,
   input  logic [IW-1:0]     rd_addr,
   output logic [KW-1:0]     rd_key,
   output logic [DATA_W-1:0] rd_value,
   // status of the entry at the compare stage
   input  logic [IW-1:0]     probe_idx,
   output logic              probe_valid,
   output logic [IW-1:0]     probe_age,
   // update port
   input  upd_cmd_type       cmd,
   input  logic [IW-1:0]     cmd_slot,
   input  logic [IW-1:0]     cmd_limit,
   input  logic [KW-1:0]     cmd_key,
   input  logic [DATA_W-1:0] cmd_value
);

   logic [KW-1:0]     key_mem   [ENTRIES];
   logic [DATA_W-1:0] value_mem [ENTRIES];
   logic [KW-1:0]     rd_key_ff;
   logic [DATA_W-1:0] rd_value_ff;
   logic              valid_ff [ENTRIES];
   logic [IW-1:0]     age_ff   [ENTRIES];

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.apply && cmd.write_key) begin
         key_mem[cmd_slot] <= cmd_key;
      end
      if (cmd.apply && cmd.write_value) begin
         value_mem[cmd_slot] <= cmd_value;
      end
      if (rd_en) begin
         rd_key_ff   <= key_mem[rd_addr];
         rd_value_ff <= value_mem[rd_addr];
      end
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

   // Valid marks and ages; a promote ages the younger valid entries, an insert every valid one
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            age_ff[i]   <= '0;
         end
      end else if (cmd.apply) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (IW'(i) == cmd_slot) begin
               valid_ff[i] <= 1'b1;
               age_ff[i]   <= '0;
            end else if (valid_ff[i] && (cmd.all_age || age_ff[i] < cmd_limit)) begin
               age_ff[i] <= age_ff[i] + IW'(1);
            end
         end
      end
   end

   assign probe_valid = valid_ff[probe_idx];
   assign probe_age   = age_ff[probe_idx];

endmodule

// ===== rtl/lkv_scan.sv =====
// Shared compare unit: one entry a cycle, key match, oldest and first free.
// Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_scan
   import lkv_pkg::*;
#(
   parameter int KW = DEF_KEY_BITS,
   parameter int IW = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              cmp_en,
   input  logic [IW-1:0]     cmp_idx,
   input  logic              entry_valid,
   input  logic [IW-1:0]     entry_age,
   input  logic [KW-1:0]     entry_key,
   input  logic [DATA_W-1:0] entry_value,
   input  logic [KW-1:0]     req_key,
   output scan_flags_type    flags,
   output logic [IW-1:0]     hit_idx,
   output logic [IW-1:0]     hit_age,
   output logic [DATA_W-1:0] hit_value,
   output logic [IW-1:0]     old_idx,
   output logic [IW-1:0]     free_idx
);

   logic              hit_ff,  hit_in;
   logic              old_ok_ff, free_ok_ff;
   logic [IW-1:0]     hit_idx_ff, hit_age_ff, old_idx_ff, old_age_ff, free_idx_ff;
   logic [DATA_W-1:0] hit_value_ff;
   logic              match, older;

   // Compare stage
   assign match  = cmp_en && !hit_ff && entry_valid && (entry_key == req_key);
   assign older  = cmp_en && entry_valid && (!old_ok_ff || entry_age > old_age_ff);
   assign hit_in = hit_ff || match;

   // Result flags
   always_ff @(posedge clock) begin
      if (reset || start) begin
         hit_ff     <= 1'b0;
         old_ok_ff  <= 1'b0;
         free_ok_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
         if (older) begin
            old_ok_ff <= 1'b1;
         end
         if (cmp_en && !entry_valid) begin
            free_ok_ff <= 1'b1;
         end
      end
   end

   // Recorded indexes and data
   always_ff @(posedge clock) begin
      if (match) begin
         hit_idx_ff   <= cmp_idx;
         hit_age_ff   <= entry_age;
         hit_value_ff <= entry_value;
      end
      if (older) begin
         old_idx_ff <= cmp_idx;
         old_age_ff <= entry_age;
      end
      if (cmp_en && !entry_valid && !free_ok_ff) begin
         free_idx_ff <= cmp_idx;
      end
   end

   assign flags.hit_now = match;
   assign flags.hit     = hit_ff;
   assign flags.old_ok  = old_ok_ff;
   assign flags.free_ok = free_ok_ff;
   assign hit_idx       = hit_idx_ff;
   assign hit_age       = hit_age_ff;
   assign hit_value     = hit_value_ff;
   assign old_idx       = old_idx_ff;
   assign free_idx      = free_idx_ff;

endmodule

// ===== rtl/lkv_ctrl.sv =====
// Sequencer: request capture, entry scan, store update and result register.
// Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_ctrl
   import lkv_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES,
   parameter int KW      = DEF_KEY_BITS,
   parameter int IW      = 4,
   parameter int CW      = 5
) (
   input  logic              clock,
   input  logic              reset,
   // requests
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_kind,
   input  logic [KW-1:0]     req_key,
   input  logic [DATA_W-1:0] req_value,
   // results
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic              rsp_hit,
   output logic [DATA_W-1:0] rsp_value,
   // capacity register
   input  logic              csr_wr_en,
   input  logic [CAP_W-1:0]  csr_wr_data,
   // store read side
   output logic              rd_en,
   output logic [IW-1:0]     rd_addr,
   output logic              cmp_en,
   output logic [IW-1:0]     cmp_idx,
   // scan unit
   output logic              scan_start,
   output logic [KW-1:0]     scan_key,
   input  scan_flags_type    flags,
   input  logic [IW-1:0]     hit_idx,
   input  logic [IW-1:0]     hit_age,
   input  logic [DATA_W-1:0] hit_value,
   input  logic [IW-1:0]     old_idx,
   input  logic [IW-1:0]     free_idx,
   // store update
   output upd_cmd_type       cmd,
   output logic [IW-1:0]     cmd_slot,
   output logic [IW-1:0]     cmd_limit,
   output logic [KW-1:0]     cmd_key,
   output logic [DATA_W-1:0] cmd_value
);

   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
   localparam int            WIDE_W   = (CAP_W > CW ? CAP_W : CW) + 1;

   state_type         state_ff, state_in;
   kind_type          kind_ff;
   logic [KW-1:0]     key_ff;
   logic [DATA_W-1:0] value_ff;
   logic [CAP_W-1:0]  cap_ff;
   logic [CW-1:0]     occ_ff, occ_in;
   logic [IW-1:0]     addr_ff, addr_in;
   logic              issue_ff, issue_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0]     cmp_idx_ff;
   logic              res_hit_ff, res_hit_in;
   logic [DATA_W-1:0] res_val_ff, res_val_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic              rsp_hit_ff;
   logic [DATA_W-1:0] rsp_val_ff;
   logic              load_rsp, scan_end;
   logic [CW-1:0]     usable;
   logic              full;

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_W'(CAP_RESET);
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // Capacity clamped to one..ENTRIES
   always_comb begin
      if (cap_ff == '0) begin
         usable = CW'(1);
      end else if (WIDE_W'(cap_ff) > WIDE_W'(ENTRIES)) begin
         usable = CW'(ENTRIES);
      end else begin
         usable = CW'(cap_ff);
      end
   end

   assign full = occ_ff >= usable;

   // Request capture
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff  <= kind_type'(req_kind);
         key_ff   <= req_key;
         value_ff <= req_value;
      end
   end

   // State and sequencing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         occ_ff     <= '0;
         issue_ff   <= 1'b0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         occ_ff     <= occ_in;
         issue_ff   <= issue_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      cmp_idx_ff <= addr_ff;
      res_hit_ff <= res_hit_in;
      res_val_ff <= res_val_in;
      if (load_rsp) begin
         rsp_hit_ff <= res_hit_ff;
         rsp_val_ff <= res_val_ff;
      end
   end

   assign scan_end = flags.hit_now || (cmp_vld_ff && cmp_idx_ff == LAST_IDX);

   // Next state and outputs
   always_comb begin
      state_in    = state_ff;
      occ_in      = occ_ff;
      addr_in     = addr_ff;
      issue_in    = issue_ff;
      cmp_vld_in  = 1'b0;
      res_hit_in  = res_hit_ff;
      res_val_in  = res_val_ff;
      req_tready  = 1'b0;
      scan_start  = 1'b0;
      rd_en       = 1'b0;
      load_rsp    = 1'b0;
      cmd         = '0;
      cmd_slot    = free_idx;
      cmd_limit   = hit_age;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               scan_start = 1'b1;
               addr_in    = '0;
               issue_in   = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_en = issue_ff;
            if (issue_ff) begin
               if (addr_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  addr_in = addr_ff + IW'(1);
               end
            end
            cmp_vld_in = issue_ff;
            if (scan_end) begin
               issue_in   = 1'b0;
               cmp_vld_in = 1'b0;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            res_val_in = MISS_VALUE;
            res_hit_in = flags.hit;
            if (flags.hit) begin
               // present key: promote, and overwrite the value on a put
               cmd.apply       = 1'b1;
               cmd.write_value = (kind_ff == KIND_PUT);
               cmd_slot        = hit_idx;
               if (kind_ff == KIND_GET) begin
                  res_val_in = hit_value;
               end
            end else if (kind_ff == KIND_PUT) begin
               cmd.all_age     = 1'b1;
               cmd.write_key   = 1'b1;
               cmd.write_value = 1'b1;
               if (full && flags.old_ok) begin
                  // evict the least recent entry and reuse its slot
                  cmd.apply = 1'b1;
                  cmd_slot  = old_idx;
               end else if (flags.free_ok) begin
                  cmd.apply = 1'b1;
                  occ_in    = full ? CW'(1) : occ_ff + CW'(1);
               end else if (full) begin
                  occ_in = '0;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               load_rsp   = 1'b1;
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_addr    = addr_ff;
   assign cmp_en     = cmp_vld_ff;
   assign cmp_idx    = cmp_idx_ff;
   assign scan_key   = key_ff;
   assign cmd_key    = key_ff;
   assign cmd_value  = value_ff;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_value  = rsp_val_ff;

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// Fully associative key-value cache with least-recently-used replacement.
// A miss scans every entry before its result is given; a hit ends the scan at
// the matching entry. One item is in work at a time: a new request is taken only
// once the last result is loaded. The scan reads one entry a cycle through the
// single key/value memory read port and the shared compare unit.
// Reset clears valid marks, ages and occupancy at once and sets capacity to 16.
`timescale 1ns / 1ps

module lru_key_value_cache
   import lkv_pkg::*;
#(
   parameter int ENTRIES  = DEF_ENTRIES,
   parameter int KEY_BITS = DEF_KEY_BITS
) (
   input  logic                clock,
   input  logic                reset,
   // request: tdata = key[31:0], value[63:32]; tuser = kind
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2*DATA_W-1:0] req_tdata,
   input  logic                req_tuser,
   // result: tdata = read_value[31:0]; tuser = hit
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_tdata,
   output logic                rsp_tuser,
   // capacity register
   input  logic                csr_wr_en,
   input  logic [CAP_W-1:0]    csr_wr_data
);

   localparam int KW = (KEY_BITS < DATA_W) ? KEY_BITS : DATA_W;
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   logic              rd_en, cmp_en, scan_start, probe_valid;
   logic [IW-1:0]     rd_addr, cmp_idx, probe_age;
   logic [KW-1:0]     rd_key, scan_key, cmd_key;
   logic [DATA_W-1:0] rd_value, hit_value, cmd_value;
   scan_flags_type    flags;
   logic [IW-1:0]     hit_idx, hit_age, old_idx, free_idx, cmd_slot, cmd_limit;
   upd_cmd_type       cmd;

   lkv_ctrl #(
      .ENTRIES (ENTRIES),
      .KW      (KW),
      .IW      (IW),
      .CW      (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_kind    (req_tuser),
      .req_key     (req_tdata[KW-1:0]),
      .req_value   (req_tdata[2*DATA_W-1:DATA_W]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_hit     (rsp_tuser),
      .rsp_value   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .cmp_en      (cmp_en),
      .cmp_idx     (cmp_idx),
      .scan_start  (scan_start),
      .scan_key    (scan_key),
      .flags       (flags),
      .hit_idx     (hit_idx),
      .hit_age     (hit_age),
      .hit_value   (hit_value),
      .old_idx     (old_idx),
      .free_idx    (free_idx),
      .cmd         (cmd),
      .cmd_slot    (cmd_slot),
      .cmd_limit   (cmd_limit),
      .cmd_key     (cmd_key),
      .cmd_value   (cmd_value)
   );

   lkv_scan #(
      .KW (KW),
      .IW (IW)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (scan_start),
      .cmp_en      (cmp_en),
      .cmp_idx     (cmp_idx),
      .entry_valid (probe_valid),
      .entry_age   (probe_age),
      .entry_key   (rd_key),
      .entry_value (rd_value),
      .req_key     (scan_key),
      .flags       (flags),
      .hit_idx     (hit_idx),
      .hit_age     (hit_age),
      .hit_value   (hit_value),
      .old_idx     (old_idx),
      .free_idx    (free_idx)
   );

   lkv_store #(
      .ENTRIES (ENTRIES),
      .KW      (KW),
      .IW      (IW)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_key      (rd_key),
      .rd_value    (rd_value),
      .probe_idx   (cmp_idx),
      .probe_valid (probe_valid),
      .probe_age   (probe_age),
      .cmd         (cmd),
      .cmd_slot    (cmd_slot),
      .cmd_limit   (cmd_limit),
      .cmd_key     (cmd_key),
      .cmd_value   (cmd_value)
   );

endmodule
